// ===== sv/sqs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the sample quartile selector.
// No dependencies.
package sqs_pkg;

    localparam int unsigned FIELD_BITS = 64;
    localparam int unsigned COUNT_BITS = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_RK0,
        ST_RK1,
        ST_RK2,
        ST_RK3,
        ST_EMIT
    } t_sqs_state;

    typedef enum logic [1:0] {
        RD_INS,
        RD_Q1,
        RD_MED,
        RD_Q3
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        logic    wr_shift;
        logic    wr_val;
        logic    cap_q1;
        logic    cap_med;
        logic    cap_q3;
        logic    emit;
    } t_sqs_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic pos_zero;
        logic gt;
        logic out_busy;
    } t_sqs_status;

endpackage

// ===== sv/sqs_smp_if.sv =====
`timescale 1ns / 1ps
// Sample input channel: valid/ready plus one sample transaction.
// Depends on sqs_pkg.
interface sqs_smp_if;
    logic                             valid;
    logic                             ready;
    logic [sqs_pkg::FIELD_BITS-1:0]   sample_value;
    logic                             last_sample;
    modport source (output valid, sample_value, last_sample, input ready);
    modport sink (input valid, sample_value, last_sample, output ready);
endinterface

// ===== sv/sqs_res_if.sv =====
`timescale 1ns / 1ps
// Result output channel: valid/ready plus quartiles, count and overflow.
// Depends on sqs_pkg.
interface sqs_res_if;
    logic                             valid;
    logic                             ready;
    logic [sqs_pkg::FIELD_BITS-1:0]   first_quartile;
    logic [sqs_pkg::FIELD_BITS-1:0]   median_value;
    logic [sqs_pkg::FIELD_BITS-1:0]   third_quartile;
    logic [sqs_pkg::COUNT_BITS-1:0]   set_count;
    logic                             overflow_flag;
    modport source (output valid, first_quartile, median_value, third_quartile,
                    set_count, overflow_flag, input ready);
    modport sink (input valid, first_quartile, median_value, third_quartile,
                  set_count, overflow_flag, output ready);
endinterface

// ===== sv/sqs_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the sample quartile selector: insertion and rank-read sequencing.
// Depends on sqs_pkg.
module sqs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sqs_pkg::t_sqs_status i_status,
    output sqs_pkg::t_sqs_cmd    o_cmd
);

    sqs_pkg::t_sqs_state r_state, n_state;
    logic                w_acc;

    assign w_acc = i_in_valid && (r_state == sqs_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sqs_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_state = sqs_pkg::ST_INS_RD;
                end
            end
            sqs_pkg::ST_INS_RD: begin
                priority if (i_status.full) begin
                    n_state = i_status.last ? sqs_pkg::ST_RK0 : sqs_pkg::ST_IDLE;
                end else if (i_status.pos_zero) begin
                    n_state = i_status.last ? sqs_pkg::ST_RK0 : sqs_pkg::ST_IDLE;
                end else begin
                    n_state = sqs_pkg::ST_INS_CMP;
                end
            end
            sqs_pkg::ST_INS_CMP: begin
                if (i_status.gt) begin
                    n_state = sqs_pkg::ST_INS_RD;
                end else begin
                    n_state = i_status.last ? sqs_pkg::ST_RK0 : sqs_pkg::ST_IDLE;
                end
            end
            sqs_pkg::ST_RK0: n_state = sqs_pkg::ST_RK1;
            sqs_pkg::ST_RK1: n_state = sqs_pkg::ST_RK2;
            sqs_pkg::ST_RK2: n_state = sqs_pkg::ST_RK3;
            sqs_pkg::ST_RK3: n_state = sqs_pkg::ST_EMIT;
            sqs_pkg::ST_EMIT: begin
                if (!i_status.out_busy) begin
                    n_state = sqs_pkg::ST_IDLE;
                end
            end
            default: n_state = sqs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == sqs_pkg::ST_IDLE);
        o_cmd      = '0;
        o_cmd.rd_sel = sqs_pkg::RD_INS;
        unique case (r_state)
            sqs_pkg::ST_IDLE: o_cmd.load = w_acc;
            sqs_pkg::ST_INS_RD: begin
                if (!i_status.full && i_status.pos_zero) begin
                    o_cmd.wr_val = 1'b1;
                end
            end
            sqs_pkg::ST_INS_CMP: begin
                o_cmd.wr_shift = i_status.gt;
                o_cmd.wr_val   = !i_status.gt;
            end
            sqs_pkg::ST_RK0: o_cmd.rd_sel = sqs_pkg::RD_Q1;
            sqs_pkg::ST_RK1: begin
                o_cmd.rd_sel = sqs_pkg::RD_MED;
                o_cmd.cap_q1 = 1'b1;
            end
            sqs_pkg::ST_RK2: begin
                o_cmd.rd_sel  = sqs_pkg::RD_Q3;
                o_cmd.cap_med = 1'b1;
            end
            sqs_pkg::ST_RK3: o_cmd.cap_q3 = 1'b1;
            sqs_pkg::ST_EMIT: o_cmd.emit = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== sv/sqs_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the sample quartile selector: sorted store, count, rank reads, result register.
// Depends on sqs_pkg.
module sqs_dp #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned SAMPLE_BITS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sqs_pkg::t_sqs_cmd              i_cmd,
    output sqs_pkg::t_sqs_status           o_status,
    input  logic [sqs_pkg::FIELD_BITS-1:0] i_sample_value,
    input  logic                           i_last_sample,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [sqs_pkg::FIELD_BITS-1:0] o_first_quartile,
    output logic [sqs_pkg::FIELD_BITS-1:0] o_median_value,
    output logic [sqs_pkg::FIELD_BITS-1:0] o_third_quartile,
    output logic [sqs_pkg::COUNT_BITS-1:0] o_set_count,
    output logic                           o_overflow_flag
);

    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned TW = CW + 2;

    logic [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic [SAMPLE_BITS-1:0] r_val, r_rd, r_q1, r_qm, r_q3;
    logic                   r_last, r_drop, r_o_valid;
    logic [CW-1:0]          r_pos, r_cnt;
    logic [AW-1:0]          w_rd_addr, w_r1, w_rm, w_r3;
    logic [TW-1:0]          w_n, w_t3, w_c1, w_c3;
    logic [CW-1:0]          w_pos_m1;

    assign w_n      = TW'(r_cnt);
    assign w_t3     = w_n + (w_n << 1);
    assign w_c1     = (w_n >> 2) + TW'(w_n[1:0] != 2'd0) - TW'(1);
    assign w_c3     = (w_t3 >> 2) + TW'(w_t3[1:0] != 2'd0) - TW'(1);
    assign w_r1     = w_c1[AW-1:0];
    assign w_r3     = w_c3[AW-1:0];
    assign w_rm     = AW'((r_cnt - CW'(1)) >> 1);
    assign w_pos_m1 = r_pos - CW'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            sqs_pkg::RD_INS: w_rd_addr = w_pos_m1[AW-1:0];
            sqs_pkg::RD_Q1:  w_rd_addr = w_r1;
            sqs_pkg::RD_MED: w_rd_addr = w_rm;
            sqs_pkg::RD_Q3:  w_rd_addr = w_r3;
            default:         w_rd_addr = w_r1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_rd_addr];
        if (i_cmd.wr_shift) begin
            r_mem[r_pos[AW-1:0]] <= r_rd;
        end else if (i_cmd.wr_val) begin
            r_mem[r_pos[AW-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val  <= i_sample_value[SAMPLE_BITS-1:0];
            r_last <= i_last_sample;
            r_pos  <= r_cnt;
        end else if (i_cmd.wr_shift) begin
            r_pos <= w_pos_m1;
        end
        if (i_cmd.cap_q1) r_q1 <= r_rd;
        if (i_cmd.cap_med) r_qm <= r_rd;
        if (i_cmd.cap_q3) r_q3 <= r_rd;
        if (i_cmd.emit) begin
            o_first_quartile <= sqs_pkg::FIELD_BITS'(r_q1);
            o_median_value   <= sqs_pkg::FIELD_BITS'(r_qm);
            o_third_quartile <= sqs_pkg::FIELD_BITS'(r_q3);
            o_set_count      <= sqs_pkg::COUNT_BITS'(r_cnt);
            o_overflow_flag  <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.load && (r_cnt == CW'(MAX_SAMPLES))) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.wr_val) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.emit) begin
                r_cnt     <= '0;
                r_drop    <= 1'b0;
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_status.full     = (r_cnt == CW'(MAX_SAMPLES));
    assign o_status.last     = r_last;
    assign o_status.pos_zero = (r_pos == '0);
    assign o_status.gt       = (r_rd > r_val);
    assign o_status.out_busy = r_o_valid && !i_out_ready;

endmodule

// ===== sv/sample_quartile_selector_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sample quartile selector.
// Depends on sqs_pkg, sqs_smp_if, sqs_res_if, sqs_ctrl, sqs_dp.
//
// Samples are kept in ascending order in a single-port-read RAM of MAX_SAMPLES
// entries by insertion. An accepted sample is dropped when the store is full and
// written at once when the store is empty. Otherwise every stored entry larger
// than it costs one RAM read and one compare-and-shift step, until the sample
// lands in place or at the bottom of the store. No new sample is taken until the
// insertion is done. After the sample marked last, three rank reads run before
// the result is loaded into the output register. That load waits while the
// output register still holds an unaccepted result. The output register holds
// the result while the next set starts loading. Samples arriving with the store
// full are dropped and reported in overflow_flag. The store needs no clearing
// pass, as only entries written in the current set are read.
module sample_quartile_selector_unit #(
    parameter int unsigned MAX_SAMPLES = 1024,
    parameter int unsigned SAMPLE_BITS = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    sqs_smp_if.sink   i_smp,
    sqs_res_if.source o_res
);

    sqs_pkg::t_sqs_cmd    w_cmd;
    sqs_pkg::t_sqs_status w_status;

    sqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sqs_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_sample_value   (i_smp.sample_value),
        .i_last_sample    (i_smp.last_sample),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_first_quartile (o_res.first_quartile),
        .o_median_value   (o_res.median_value),
        .o_third_quartile (o_res.third_quartile),
        .o_set_count      (o_res.set_count),
        .o_overflow_flag  (o_res.overflow_flag)
    );

endmodule
